>>> rtl/sqsd_pkg.sv
package sqsd_pkg;

  localparam int MAX_WINDOWS      = 8;
  localparam int QUEUE_DEPTH      = 16;
  localparam int MAX_SERVICE_TIME = 10;

  localparam int WIN_W  = $clog2(MAX_WINDOWS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W  = $clog2(MAX_WINDOWS + 1);
  localparam int ADDR_W = WIN_W + PTR_W;
  localparam int TIME_W = 4;
  localparam int CFG_W  = 4;
  localparam int MEM_DEPTH = MAX_WINDOWS * QUEUE_DEPTH;

  // One tick's result, handed from the controller to the output register.
  typedef struct packed {
    logic                   assigned;
    logic [WIN_W-1:0]       window;
    logic                   dropped;
    logic [MAX_WINDOWS-1:0] done_mask;
  } res_t;

endpackage

>>> rtl/sqsd_job_ram.sv
module sqsd_job_ram
  import sqsd_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [TIME_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0] mem [MEM_DEPTH];
  logic [TIME_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sqsd_ctrl.sv
module sqsd_ctrl
  import sqsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  live_cnt,
  input  logic              in_valid,
  input  logic              in_arrive,
  input  logic [TIME_W-1:0] in_service_time,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_take,
  output res_t              res
);

  typedef enum logic [1:0] {S_IDLE, S_SERVE, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic [MAX_WINDOWS-1:0][PTR_W-1:0] head_r, head_nxt;
  logic [MAX_WINDOWS-1:0][PTR_W-1:0] tail_r, tail_nxt;
  logic [MAX_WINDOWS-1:0][OCC_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [WIN_W-1:0] pend_idx_r, pend_idx_nxt;
  res_t             res_r, res_nxt;

  logic [WIN_W-1:0]  best;
  logic [TIME_W-1:0] st_clamp;
  logic [WIN_W-1:0]  rd_win;
  logic              start;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [TIME_W-1:0] mem_wdata, mem_rdata;

  sqsd_job_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign start  = in_valid && (state_r == S_IDLE);
  assign rd_win = rd_idx_r[WIN_W-1:0];

  // shortest active queue, lowest index wins ties
  always_comb begin
    best = '0;
    for (int i = 1; i < MAX_WINDOWS; i++) begin
      if ((CNT_W'(i) < live_cnt) && (occ_r[i] < occ_r[best])) begin
        best = WIN_W'(i);
      end
    end
  end

  always_comb begin
    if (in_service_time == '0) begin
      st_clamp = TIME_W'(1);
    end else if (in_service_time > TIME_W'(MAX_SERVICE_TIME)) begin
      st_clamp = TIME_W'(MAX_SERVICE_TIME);
    end else begin
      st_clamp = in_service_time;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    occ_nxt      = occ_r;
    rd_idx_nxt   = rd_idx_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    res_nxt      = res_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = {rd_win, head_r[rd_win]};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt  = S_SERVE;
          rd_idx_nxt = '0;
          pend_v_nxt = 1'b0;
          res_nxt    = '0;
          if (in_arrive) begin
            if (occ_r[best] >= OCC_W'(QUEUE_DEPTH)) begin
              res_nxt.dropped = 1'b1;
            end else begin
              mem_we         = 1'b1;
              mem_waddr      = {best, tail_r[best]};
              mem_wdata      = st_clamp;
              tail_nxt[best] = tail_r[best] + PTR_W'(1);
              occ_nxt[best]  = occ_r[best] + OCC_W'(1);
              res_nxt.assigned = 1'b1;
              res_nxt.window   = best;
            end
          end
        end
      end

      S_SERVE: begin
        // issue the head read for one window while the previous one writes back
        mem_re       = (rd_idx_r < live_cnt) && (occ_r[rd_win] != '0);
        pend_v_nxt   = mem_re;
        pend_idx_nxt = rd_win;
        if (rd_idx_r < live_cnt) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (pend_v_r) begin
          mem_we    = 1'b1;
          mem_waddr = {pend_idx_r, head_r[pend_idx_r]};
          if (mem_rdata <= TIME_W'(1)) begin
            mem_wdata                    = '0;
            head_nxt[pend_idx_r]         = head_r[pend_idx_r] + PTR_W'(1);
            occ_nxt[pend_idx_r]          = occ_r[pend_idx_r] - OCC_W'(1);
            res_nxt.done_mask[pend_idx_r] = 1'b1;
          end else begin
            mem_wdata = mem_rdata - TIME_W'(1);
          end
        end else if (rd_idx_r >= live_cnt) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      occ_r      <= '0;
      rd_idx_r   <= '0;
      pend_v_r   <= 1'b0;
      pend_idx_r <= '0;
      res_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      occ_r      <= occ_nxt;
      rd_idx_r   <= rd_idx_nxt;
      pend_v_r   <= pend_v_nxt;
      pend_idx_r <= pend_idx_nxt;
      res_r      <= res_nxt;
    end
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

>>> rtl/shortest_queue_service_dispatch.sv
// Join-shortest-queue dispatcher over up to eight service windows.
// Input channel (in_valid / in_stall): one request per time tick, carrying an
// optional arriving job (in_arrive) and its service time (in_service_time).
// Output channel (out_valid / out_stall): exactly one result per request:
// assigned flag, chosen window, drop flag and the mask of completed windows.
// Config: cfg_we / cfg_wdata write active_windows (reset 8); write only while
// no request is in flight.
// Sequencing: a request's result is ready for the output register once the
// service pass over the n active windows (eight after reset) is done, and
// the next request can be taken in the cycle after the result moves there.
// The single job-store RAM sets the length of the pass: each active
// window's head job is read, decremented and written back, one window per
// cycle, pipelined over the RAM's registered read.
// in_stall is high from acceptance until the result moves into the output
// register, so one request is in work at a time; a finished result may wait
// in the output register while the next request is taken.
// If the receiver stalls, the result holds on the out_ ports; a second result
// waits in the controller and in_stall stays high until it can move.
// Reset (rst_n low, synchronous) empties all queues and sets 8 windows.
module shortest_queue_service_dispatch
  import sqsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_arrive,
  input  logic [TIME_W-1:0]      in_service_time,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_assigned,
  output logic [WIN_W-1:0]       out_window,
  output logic                   out_dropped,
  output logic [MAX_WINDOWS-1:0] out_done_mask
);

  logic [CFG_W-1:0] active_windows_r;
  logic [CNT_W-1:0] live_cnt;
  logic             idle;
  logic             res_valid;
  logic             res_take;
  res_t             res;
  logic             out_valid_r;
  res_t             out_r;

  // register value zero means one window, anything past the bank means all
  always_comb begin
    if (active_windows_r == '0) begin
      live_cnt = CNT_W'(1);
    end else if (active_windows_r > CFG_W'(MAX_WINDOWS)) begin
      live_cnt = CNT_W'(MAX_WINDOWS);
    end else begin
      live_cnt = CNT_W'(active_windows_r);
    end
  end

  sqsd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .live_cnt        (live_cnt),
    .in_valid        (in_valid),
    .in_arrive       (in_arrive),
    .in_service_time (in_service_time),
    .idle            (idle),
    .res_valid       (res_valid),
    .res_take        (res_take),
    .res             (res)
  );

  // output register frees up when empty or when the receiver takes it
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_windows_r <= CFG_W'(MAX_WINDOWS);
      out_valid_r      <= 1'b0;
      out_r            <= '0;
    end else begin
      if (cfg_we) begin
        active_windows_r <= cfg_wdata;
      end
      if (res_take) begin
        out_valid_r <= 1'b1;
        out_r       <= res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall      = !idle;
  assign out_valid     = out_valid_r;
  assign out_assigned  = out_r.assigned;
  assign out_window    = out_r.window;
  assign out_dropped   = out_r.dropped;
  assign out_done_mask = out_r.done_mask;

endmodule

>>> bench/shortest_queue_service_dispatch_test.sv
`timescale 1ns / 100ps

module shortest_queue_service_dispatch_test;
  import sqsd_pkg::*;

  // Idle cycles with nothing accepted on either side before giving up.
  localparam int STALL_LIMIT = 3000;
  // Cycles of quiet after the last result before the register is touched.
  localparam int SETTLE_CYCLES = 20;
  localparam int IDLE_PCT = 22;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_arrive = 1'b0;
  logic [TIME_W-1:0]      in_service_time = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_assigned;
  logic [WIN_W-1:0]       out_window;
  logic                   out_dropped;
  logic [MAX_WINDOWS-1:0] out_done_mask;

  shortest_queue_service_dispatch u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_arrive       (in_arrive),
    .in_service_time (in_service_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_assigned    (out_assigned),
    .out_window      (out_window),
    .out_dropped     (out_dropped),
    .out_done_mask   (out_done_mask)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the dispatcher: one FIFO of remaining service times per window.
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] job_left [MAX_WINDOWS][QUEUE_DEPTH];
  logic [PTR_W-1:0]  q_head [MAX_WINDOWS];
  logic [PTR_W-1:0]  q_tail [MAX_WINDOWS];
  logic [OCC_W-1:0]  q_fill [MAX_WINDOWS];
  logic [CFG_W-1:0]  windows_cfg = CFG_W'(8);

  res_t pending_results[$];  // expected results, oldest first
  int   error_count = 0;
  bit   calm = 1'b0;         // set to suppress all random idling on both sides

  function automatic void add_expected(res_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic res_t take_expected();
    res_t r;
    r = pending_results[0];
    pending_results.delete(0);
    return r;
  endfunction

  initial begin
    for (int w = 0; w < MAX_WINDOWS; w++) begin
      q_head[w] = '0;
      q_tail[w] = '0;
      q_fill[w] = '0;
    end
  end

  // Advance the shadow by one tick and return the result it should produce.
  function automatic res_t dispatch_tick(logic arrive, logic [TIME_W-1:0] svc);
    res_t              r;
    int                n;
    int                best;
    logic [TIME_W-1:0] t;
    r = '0;
    // zero windows act as one, anything above the bank size as the whole bank
    n = (windows_cfg == 0) ? 1 :
        (int'(windows_cfg) > MAX_WINDOWS) ? MAX_WINDOWS : int'(windows_cfg);
    if (arrive) begin
      best = 0;
      for (int i = 1; i < n; i++)
        if (q_fill[i] < q_fill[best]) best = i;  // strict: ties stay low
      if (int'(q_fill[best]) >= QUEUE_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        t = (svc == 0) ? TIME_W'(1) :
            (int'(svc) > MAX_SERVICE_TIME) ? TIME_W'(MAX_SERVICE_TIME) : svc;
        job_left[best][q_tail[best]] = t;
        q_tail[best] = PTR_W'((int'(q_tail[best]) + 1) % QUEUE_DEPTH);
        q_fill[best] = q_fill[best] + 1'b1;
        r.assigned = 1'b1;
        r.window = WIN_W'(best);
      end
    end
    // service pass runs after the join, so a fresh job is served this tick
    for (int i = 0; i < n; i++) begin
      if (q_fill[i] != 0) begin
        if (job_left[i][q_head[i]] <= 1) begin
          job_left[i][q_head[i]] = '0;
          q_head[i] = PTR_W'((int'(q_head[i]) + 1) % QUEUE_DEPTH);
          q_fill[i] = q_fill[i] - 1'b1;
          r.done_mask[i] = 1'b1;
        end else begin
          job_left[i][q_head[i]] = job_left[i][q_head[i]] - 1'b1;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Valid is left high after acceptance; the next call either
  // keeps it high (back to back) or drops it in its gap loop.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic arrive, input logic [TIME_W-1:0] svc);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid        <= 1'b0;
      in_arrive       <= 1'($urandom);
      in_service_time <= TIME_W'($urandom);
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_arrive       <= arrive;
    in_service_time <= svc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    add_expected(dispatch_tick(arrive, svc));
  endtask

  // Drop valid and wait for every outstanding result, then let the block settle.
  task automatic drain_results;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic set_windows(input logic [CFG_W-1:0] count);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= CFG_W'($urandom);
    windows_cfg = count;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default eight windows: time clamping, idle ticks, same-tick completion,
  // and ties resolving to the lowest window.
  task automatic test_time_extremes;
    send_request(1'b1, TIME_W'(0));   // clamps to one, done on arrival
    send_request(1'b1, TIME_W'(15));  // clamps to max service time
    send_request(1'b1, TIME_W'(10));
    send_request(1'b1, TIME_W'(1));
    send_request(1'b0, TIME_W'(15));  // no arrival, time ignored
    send_request(1'b0, TIME_W'(0));
    send_request(1'b1, TIME_W'(5));
    send_request(1'b1, TIME_W'(5));
  endtask

  // One window, long jobs back to back: the FIFO fills and later arrivals drop.
  task automatic test_queue_full;
    set_windows(CFG_W'(1));
    for (int k = 0; k < 19; k++) send_request(1'b1, TIME_W'(15));
  endtask

  // Phases at different window counts and loads. Lowering the count while
  // queues are loaded freezes the upper windows until the count comes back.
  task automatic test_random_load;
    logic [CFG_W-1:0] plan [12];
    int               load_pct;
    int               items;
    logic [TIME_W-1:0] svc;
    plan = '{CFG_W'(8), CFG_W'(1), CFG_W'(3), CFG_W'(15), CFG_W'(0), CFG_W'(5),
             CFG_W'(2), CFG_W'(8), CFG_W'(7), CFG_W'(4), CFG_W'(6), CFG_W'(8)};
    for (int p = 0; p < 12; p++) begin
      set_windows(plan[p]);
      calm = (p == 7);  // one long stretch with no idling at all
      items = $urandom_range(105, 135);
      for (int k = 0; k < items; k++) begin
        // load swings every so often so queues both fill up and drain
        if (k % 30 == 0) begin
          case ($urandom_range(0, 3))
            0: load_pct = 25;
            1: load_pct = 55;
            2: load_pct = 85;
            default: load_pct = 100;
          endcase
        end
        if ($urandom_range(0, 99) < 80) svc = TIME_W'($urandom_range(1, MAX_SERVICE_TIME));
        else svc = TIME_W'($urandom_range(0, 15));
        send_request($urandom_range(0, 99) < load_pct, svc);
      end
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_time_extremes();
    test_queue_full();
    test_random_load();
    drain_results();
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("shortest_queue_service_dispatch_test: done, clean");
    end else begin
      $display("shortest_queue_service_dispatch_test: done, errors");
    end
    $finish;
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: assigned %0d window %0d dropped %0d done %0h",
               out_assigned, out_window, out_dropped, out_done_mask);
        error_count++;
      end else begin
        want = take_expected();
        if (out_assigned !== want.assigned) begin
          $error("assigned: expected %0d, got %0d", want.assigned, out_assigned);
          error_count++;
        end
        if (out_window !== want.window) begin
          $error("window: expected %0d, got %0d", want.window, out_window);
          error_count++;
        end
        if (out_dropped !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, out_dropped);
          error_count++;
        end
        if (out_done_mask !== want.done_mask) begin
          $error("done_mask: expected %h, got %h", want.done_mask, out_done_mask);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any request or result moving.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("shortest_queue_service_dispatch_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> filelist.f
rtl/sqsd_pkg.sv
rtl/sqsd_job_ram.sv
rtl/sqsd_ctrl.sv
rtl/shortest_queue_service_dispatch.sv
bench/shortest_queue_service_dispatch_test.sv
